@@ src/lrt_pkg.sv @@
// Shared types and constants for the Luby restart term unit.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

    // Widths fixed by the register and result formats.
    localparam int EXP_BITS  = 5;
    localparam int BASE_BITS = 5;

    localparam logic [BASE_BITS-1:0] BASE_RESET = 5'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic grow;
        logic shrink;
        logic pow_init;
        logic pow_step;
        logic finish;
        logic saturate;
    } t_lrt_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fits;
        logic at_end;
        logic pow_done;
        logic pow_ovf;
    } t_lrt_status;

endpackage

`default_nettype wire

@@ src/lrt_ctrl.sv @@
// Controller state machine for the Luby restart term unit.
// Depends on lrt_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lrt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire lrt_pkg::t_lrt_status i_status,
    output lrt_pkg::t_lrt_cmd        o_cmd,
    output logic                     o_busy,
    output logic                     o_valid
);
    import lrt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GROW   = 3'd1;
    localparam logic [2:0] ST_SHRINK = 3'd2;
    localparam logic [2:0] ST_POW    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_GROW;
                end
            end
            ST_GROW: begin
                if (i_status.fits) begin
                    n_state = ST_SHRINK;
                end else begin
                    o_cmd.grow = 1'b1;
                end
            end
            ST_SHRINK: begin
                if (i_status.at_end) begin
                    o_cmd.pow_init = 1'b1;
                    n_state        = ST_POW;
                end else begin
                    o_cmd.shrink = 1'b1;
                end
            end
            ST_POW: begin
                // The step count is checked before overflow, so a product that
                // would overflow after the last step is never flagged.
                if (i_status.pow_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_DONE;
                end else if (i_status.pow_ovf) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.saturate = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.pow_step = 1'b1;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

endmodule

`default_nettype wire

@@ src/lrt_datapath.sv @@
// Datapath of the Luby restart term unit: base register, size and position
// registers, exponent counter, power multiplier and result registers. Uses lrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrt_datapath #(
    parameter int INDEX_BITS = 16,
    parameter int TERM_BITS  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lrt_pkg::BASE_BITS-1:0] i_cfg_wdata,
    input  wire logic [INDEX_BITS-1:0]         i_index,
    input  wire lrt_pkg::t_lrt_cmd             i_cmd,
    output lrt_pkg::t_lrt_status               o_status,
    output logic [TERM_BITS-1:0]               o_term,
    output logic [lrt_pkg::EXP_BITS-1:0]       o_exponent,
    output logic                               o_saturated
);
    import lrt_pkg::*;

    localparam int SIZE_W = INDEX_BITS + 1;
    localparam int PROD_W = TERM_BITS + BASE_BITS;

    logic [BASE_BITS-1:0]  r_base;
    logic [INDEX_BITS-1:0] r_pos;
    logic [SIZE_W-1:0]     r_size;
    logic [EXP_BITS-1:0]   r_exp;
    logic [EXP_BITS-1:0]   r_cnt;
    logic [TERM_BITS-1:0]  r_prod;
    logic [TERM_BITS-1:0]  r_term;
    logic [EXP_BITS-1:0]   r_exp_out;
    logic                  r_sat;

    logic [SIZE_W-1:0]     w_pos_ext;
    logic [SIZE_W-1:0]     w_half;
    logic [INDEX_BITS-1:0] w_pos_red;
    logic [PROD_W-1:0]     w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    assign w_pos_ext = {1'b0, r_pos};
    // Sizes are always of the form 2^k-1, so (size-1)/2 is a plain shift.
    assign w_half    = r_size >> 1;
    // The position stays below twice the new size, so one subtract reduces it.
    assign w_pos_red = (w_pos_ext >= w_half) ? (r_pos - w_half[INDEX_BITS-1:0]) : r_pos;
    assign w_prod    = {{BASE_BITS{1'b0}}, r_prod} * {{TERM_BITS{1'b0}}, r_base};

    assign o_status.fits     = (r_size > w_pos_ext);
    assign o_status.at_end   = ((r_size - SIZE_W'(1)) == w_pos_ext);
    assign o_status.pow_done = (r_cnt == '0);
    assign o_status.pow_ovf  = |w_prod[PROD_W-1:TERM_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos  <= i_index;
            r_size <= SIZE_W'(1);
            r_exp  <= '0;
        end else if (i_cmd.grow) begin
            r_size <= {r_size[SIZE_W-2:0], 1'b1};
            r_exp  <= r_exp + EXP_BITS'(1);
        end else if (i_cmd.shrink) begin
            r_size <= w_half;
            r_exp  <= r_exp - EXP_BITS'(1);
            r_pos  <= w_pos_red;
        end
        if (i_cmd.pow_init) begin
            r_cnt  <= r_exp;
            r_prod <= TERM_BITS'(1);
        end else if (i_cmd.pow_step) begin
            r_cnt  <= r_cnt - EXP_BITS'(1);
            r_prod <= w_prod[TERM_BITS-1:0];
        end
        if (i_cmd.finish) begin
            r_term    <= i_cmd.saturate ? {TERM_BITS{1'b1}} : r_prod;
            r_sat     <= i_cmd.saturate;
            r_exp_out <= r_exp;
        end
    end

    assign o_term      = r_term;
    assign o_exponent  = r_exp_out;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

@@ src/luby_restart_term_unit.sv @@
// Top level of the Luby restart term unit: controller plus datapath.
// Depends on lrt_pkg, lrt_ctrl and lrt_datapath.
//
// Usage: write the base through i_cfg_we / i_cfg_wdata (reset value 2) while
// the unit is idle. Present an index on i_index with start high; the
// transaction is taken at a clock edge where busy is low. The unit then
// grows the subsequence size 2^k-1 one step a cycle until the index fits,
// shrinks it one step a cycle while reducing the index, and raises the base
// to the exponent with one multiply a cycle, stopping early on overflow.
// After acceptance the unit passes through the grow, shrink and power
// steps, ending the power step early when the product saturates; then
// o_valid is high for exactly one cycle with o_term, o_exponent and
// o_saturated. busy drops after that cycle, so a new index is taken only
// once the last result has been shown; the two shift/compare loops and the
// single multiplier serve one index at a time. The receiver cannot stall;
// the result registers hold until the next transaction finishes.
// Reset returns the controller to idle and the base to 2.
`timescale 1ns / 1ps
`default_nettype none

module luby_restart_term_unit #(
    parameter int INDEX_BITS = 16,
    parameter int TERM_BITS  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lrt_pkg::BASE_BITS-1:0] i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [INDEX_BITS-1:0]         i_index,
    output logic                               o_valid,
    output logic [TERM_BITS-1:0]               o_term,
    output logic [lrt_pkg::EXP_BITS-1:0]       o_exponent,
    output logic                               o_saturated
);
    import lrt_pkg::*;

    t_lrt_cmd    w_cmd;
    t_lrt_status w_status;

    lrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    lrt_datapath #(
        .INDEX_BITS (INDEX_BITS),
        .TERM_BITS  (TERM_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_index     (i_index),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_term      (o_term),
        .o_exponent  (o_exponent),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire

@@ src/lrt_checker.sv @@
// Port-level checker for the Luby restart term unit, with its bind statement.
// Depends on lrt_pkg and attaches to luby_restart_term_unit.
`timescale 1ns / 1ps
`default_nettype none

module lrt_checker #(
    parameter int TERM_BITS = 32
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_valid,
    input wire logic [TERM_BITS-1:0]        o_term,
    input wire logic [lrt_pkg::EXP_BITS-1:0] o_exponent,
    input wire logic                        o_saturated
);
    import lrt_pkg::*;

    // An accepted transaction keeps the unit busy until its result is shown.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting a transaction");

    // A result is shown while busy and the unit is free right after it.
    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy ##1 (!busy && !o_valid))
        else $error("result strobe not followed by release");

    // A saturated result carries the all-ones term.
    a_sat_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_term == {TERM_BITS{1'b1}}))
        else $error("saturated result without clamped term");

    // Exponent zero always gives a term of one without saturation.
    a_exp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_exponent == '0)) |-> ((o_term == TERM_BITS'(1)) && !o_saturated))
        else $error("exponent zero with term other than one");

endmodule

bind luby_restart_term_unit lrt_checker #(
    .TERM_BITS (TERM_BITS)
) u_lrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_term      (o_term),
    .o_exponent  (o_exponent),
    .o_saturated (o_saturated)
);

`default_nettype wire

@@ dv/luby_restart_term_unit_tb.sv @@
// Self-checking testbench for luby_restart_term_unit: directed and random indices.
// Depends on lrt_pkg and luby_restart_term_unit; a scoreboard class predicts each term.
`timescale 1ns / 1ps

module luby_restart_term_unit_tb;
    import lrt_pkg::*;

    localparam int INDEX_W    = 16;
    localparam int TERM_W     = 32;
    localparam int CLK_PERIOD = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 95;
    localparam int QUIET_AFTER   = 1300;

    class luby_term_scoreboard;
        typedef struct {
            logic [TERM_W-1:0]   term;
            logic [EXP_BITS-1:0] exponent;
            logic                saturated;
        } t_luby_term;

        t_luby_term           pending_terms[$];
        logic [BASE_BITS-1:0] base_reg;
        int                   errors;

        function new();
            base_reg = BASE_RESET;
            errors   = 0;
        endfunction

        function void set_base(logic [BASE_BITS-1:0] value);
            base_reg = value;
        endfunction

        function int pending();
            return pending_terms.size();
        endfunction

        // Grow sizes 2^k-1 until the position fits, then shrink and reduce
        // until the position sits at the last slot of a subsequence.
        function logic [EXP_BITS-1:0] calc_luby_exponent(logic [INDEX_W-1:0] idx);
            longint unsigned size;
            longint unsigned pos;
            int unsigned     e;
            size = 1;
            pos  = 64'(idx);
            e    = 0;
            while (size < pos + 1) begin
                size = 2 * size + 1;
                e++;
            end
            while (size - 1 != pos) begin
                size = (size - 1) >> 1;
                if (e > 0) begin
                    e--;
                end
                if (size == 0) begin
                    break;
                end
                pos = pos % size;
            end
            return e[EXP_BITS-1:0];
        endfunction

        function t_luby_term calc_luby_term(logic [INDEX_W-1:0] idx);
            t_luby_term      res;
            longint unsigned lim;
            longint unsigned prod;
            longint unsigned b;
            lim  = (64'd1 << TERM_W) - 1;
            prod = 1;
            b    = 64'(base_reg);
            res.exponent  = calc_luby_exponent(idx);
            res.saturated = 1'b0;
            for (int i = 0; i < res.exponent; i++) begin
                if (b != 0 && prod > lim / b) begin
                    res.saturated = 1'b1;
                    prod = lim;
                    break;
                end
                prod = prod * b;
            end
            res.term = prod[TERM_W-1:0];
            return res;
        endfunction

        function void note_index(logic [INDEX_W-1:0] idx);
            pending_terms.push_back(calc_luby_term(idx));
        endfunction

        function void check_term(logic [TERM_W-1:0] term, logic [EXP_BITS-1:0] exponent,
                                 logic saturated);
            t_luby_term exp_res;
            if (pending_terms.size() == 0) begin
                $error("result with no transaction pending: term=%0d exponent=%0d",
                       term, exponent);
                errors++;
                return;
            end
            exp_res = pending_terms.pop_front();
            if (term !== exp_res.term) begin
                $error("term: expected %0d, got %0d", exp_res.term, term);
                errors++;
            end
            if (exponent !== exp_res.exponent) begin
                $error("exponent: expected %0d, got %0d", exp_res.exponent, exponent);
                errors++;
            end
            if (saturated !== exp_res.saturated) begin
                $error("saturated: expected %0d, got %0d", exp_res.saturated, saturated);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [BASE_BITS-1:0]  i_cfg_wdata = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [INDEX_W-1:0]    i_index = '0;
    logic                  o_valid;
    logic [TERM_W-1:0]     o_term;
    logic [EXP_BITS-1:0]   o_exponent;
    logic                  o_saturated;

    luby_term_scoreboard   sb = new();
    int                    stall_cycles = 0;
    int                    sent_items = 0;

    luby_restart_term_unit #(
        .INDEX_BITS(INDEX_W),
        .TERM_BITS (TERM_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .start      (start),
        .busy       (busy),
        .i_index    (i_index),
        .o_valid    (o_valid),
        .o_term     (o_term),
        .o_exponent (o_exponent),
        .o_saturated(o_saturated)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_term(o_term, o_exponent, o_saturated);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_index(input logic [INDEX_W-1:0] idx, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            gap = int'($urandom_range(1, 6));
            start   = 1'b0;
            i_index = INDEX_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_index = idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_index(idx);
        sent_items++;
        @(negedge i_clk);
    endtask

    // The register is only written once every transaction has drained.
    task automatic write_base(input logic [BASE_BITS-1:0] value);
        start = 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = BASE_BITS'($urandom);
        sb.set_base(value);
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        int k;
        k = int'($urandom_range(1, INDEX_W));
        case ($urandom_range(0, 9)) inside
            [0:3]:   return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
            [4:5]:   return INDEX_W'((1 << k) - 2);
            [6:7]:   return INDEX_W'($urandom & ((1 << k) - 1));
            8:       return INDEX_W'((1 << k) - 1);
            default: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return INDEX_W'((1 << INDEX_W) - 2);
                endcase
            end
        endcase
    endfunction

    initial begin
        logic [BASE_BITS-1:0] phase_base;
        logic [INDEX_W-1:0]   dir_idx [12];

        dir_idx = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd6, 16'd14,
                    16'd30, 16'hAAAA, 16'h5555, 16'd32766,
                    16'd65534, 16'd65535};

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset base first, across the index extremes and subsequence ends.
        foreach (dir_idx[i]) send_index(dir_idx[i], 1'b0);
        // Base sixteen overflows the term for large exponents.
        write_base(5'd16);
        send_index(16'd6, 1'b0);
        send_index(16'd62, 1'b0);
        send_index(16'd65534, 1'b0);
        // Base zero gives 1 only for a zero exponent.
        write_base(5'd0);
        send_index(16'd0, 1'b0);
        send_index(16'd2, 1'b0);
        send_index(16'd65534, 1'b0);
        write_base(5'd31);
        send_index(16'd14, 1'b0);
        send_index(16'd65534, 1'b0);
        write_base(5'd1);
        send_index(16'd65534, 1'b0);
        write_base(5'd17);
        send_index(16'd254, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0:       phase_base = (p == 0) ? 5'd2 : 5'd31;
                1:       phase_base = (p == 1) ? 5'd0 : 5'd16;
                default: phase_base = BASE_BITS'($urandom_range(0, 31));
            endcase
            if (p == 2) begin
                phase_base = 5'd1;
            end
            write_base(phase_base);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_index(pick_index(), sent_items < QUIET_AFTER);
            end
        end

        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lrt_pkg.sv
src/lrt_ctrl.sv
src/lrt_datapath.sv
src/luby_restart_term_unit.sv
src/lrt_checker.sv
dv/luby_restart_term_unit_tb.sv
